[hdl/fpc_pkg.sv]
// Shared types, constants and helpers for the feedback peak compressor.
// Used by fpc_div, feedback_peak_compressor and tb; depends on nothing else.
`default_nettype none

package fpc_pkg;

   // field widths
   localparam int SAMPLE_W  = 16;
   localparam int OUT_W     = 25;
   localparam int GAIN_W    = 16;
   localparam int ENV_W     = 17;
   localparam int CSR_W     = 16;
   localparam int CSR_IDX_W = 2;

   // shared multiplier
   localparam int MUL_A_W = 25;
   localparam int MUL_B_W = 18;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;

   // envelope and gain law
   localparam int THRESHOLD        = 3000;
   localparam int ENV_LIMIT        = 65536;
   localparam int RATE_OFFSET      = 300;
   localparam int DIV_LIMIT        = 32768;
   localparam int GAIN_BASE        = 256;
   localparam int UNITY_GAIN       = 32768;
   localparam int INPUT_GAIN_RESET = 128;

   // gain divider: 2^23 / denominator, one quotient bit per cycle
   localparam int DIV_NUM_W = 24;
   localparam int DIV_STEPS = DIV_NUM_W;
   localparam int DIV_CNT_W = 5;
   localparam int DIV_DEN_W = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_INPUT_GAIN   = 2'd0,
      CSR_ATTACK_RATE  = 2'd1,
      CSR_RELEASE_RATE = 2'd2,
      CSR_RATIO_AMOUNT = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_GAIN,
      ST_MUL_MAKEUP,
      ST_ATTACK,
      ST_ENV,
      ST_MUL_RATIO,
      ST_DIV_START,
      ST_DIV_WAIT
   } fpc_state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   // magnitude of a 16-bit two's complement value; -32768 gives 32768
   function automatic logic [15:0] mag16(input logic [15:0] v);
      logic [15:0] neg;
      neg = 16'(~v + 16'd1);
      return v[15] ? neg : v;
   endfunction

endpackage

`default_nettype wire

[hdl/fpc_div.sv]
// Restoring divider for the compressor gain: quotient = 2^23 / denom.
// One quotient bit per cycle; depends on fpc_pkg.
`default_nettype none

module fpc_div
   import fpc_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [DIV_DEN_W-1:0] denom,
   output logic      [GAIN_W-1:0]    quotient,
   output div_status_type            status
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_NUM_W-1:0] dvd_ff, dvd_in;
   logic [GAIN_W-1:0]    quot_ff, quot_in;

   logic [DIV_DEN_W:0]   trial;
   logic [DIV_DEN_W:0]   diff;
   logic                 fits;
   logic                 last_step;

   // trial subtract of the shifted remainder
   always_comb begin
      trial     = {rem_ff, dvd_ff[DIV_NUM_W-1]};
      diff      = trial - {1'b0, den_ff};
      fits      = trial >= {1'b0, den_ff};
      last_step = cnt_ff == DIV_CNT_W'(DIV_STEPS - 1);
   end

   // next values
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      quot_in = quot_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         den_in  = denom;
         rem_in  = '0;
         dvd_in  = {1'b1, {(DIV_NUM_W-1){1'b0}}};
         quot_in = '0;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
         dvd_in  = {dvd_ff[DIV_NUM_W-2:0], 1'b0};
         quot_in = {quot_ff[GAIN_W-2:0], fits};
         cnt_in  = cnt_ff + DIV_CNT_W'(1);
         if (last_step) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      dvd_ff  <= dvd_in;
      quot_ff <= quot_in;
   end

   assign quotient    = quot_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

`default_nettype wire

[hdl/feedback_peak_compressor.sv]
// Feedback peak compressor top level: sequencer, shared multiplier, state.
// Depends on fpc_pkg and fpc_div.
//
//   port group  dir  handshake          payload
//   req_        in   req_valid/ready    req_sample_in   s16
//   rsp_        out  rsp_valid/ready    rsp_sample_out  s25, rsp_gain_now u16
//   csr_        in   csr_we             csr_index 2b, csr_wdata s16
//
// Each sample passes, acceptance to acceptance, through six sequencer steps
// around the shared 25x18 multiplier, the divider's quotient bits plus its done
// cycle, and the idle state that takes the next beat; the divider is the longest part.
// Reset is synchronous and restores unity gain, a zero envelope and the
// register defaults. The result beat is registered; a stalled rsp_ delays
// the sequencer only if the previous result has not been taken yet.
`default_nettype none

module feedback_peak_compressor
   import fpc_pkg::*;
(
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic signed [SAMPLE_W-1:0]  req_sample_in,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic signed [OUT_W-1:0]          rsp_sample_out,
   output logic        [GAIN_W-1:0]         rsp_gain_now,
   input  wire logic                        csr_we,
   input  wire logic [CSR_IDX_W-1:0]        csr_index,
   input  wire logic [CSR_W-1:0]            csr_wdata
);

   // configuration registers
   logic [CSR_W-1:0] input_gain_ff, input_gain_in;
   logic [CSR_W-1:0] attack_rate_ff, attack_rate_in;
   logic [CSR_W-1:0] release_rate_ff, release_rate_in;
   logic [CSR_W-1:0] ratio_amount_ff, ratio_amount_in;

   // sequencer and state
   fpc_state_type        state_ff, state_in;
   logic [GAIN_W-1:0]    vca_ff, vca_in;
   logic [ENV_W-1:0]     env_ff, env_in;
   logic                 over_pos_ff, over_pos_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic signed [SAMPLE_W-1:0] x_ff, x_in;
   logic [GAIN_W-1:0]          used_ff, used_in;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic signed [OUT_W-1:0]    rsp_sample_ff, rsp_sample_in;
   logic [GAIN_W-1:0]          rsp_gain_ff, rsp_gain_in;

   // control from the output decoder
   logic prod_en;
   logic rsp_load;
   logic env_en;
   logic div_start;
   logic vca_load;
   logic slot_free;

   // shared multiplier
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  mul_p;

   // datapath terms
   logic signed [SAMPLE_W-1:0] y1;
   logic signed [OUT_W-1:0]    y;
   logic [OUT_W-1:0]           y_neg;
   logic [OUT_W-2:0]           y_mag;
   logic [OUT_W-2:0]           over_mag;
   logic                       over_pos;
   logic [CSR_W-1:0]           att_factor;
   logic [CSR_W-1:0]           rel_sum;
   logic [6:0]                 rel_step;
   logic [18:0]                att_inc;
   logic [19:0]                att_sum;
   logic [ENV_W-1:0]           env_att;
   logic [ENV_W-1:0]           env_rel;
   logic [17:0]                div_raw;
   logic [DIV_DEN_W-1:0]       div_clamp;
   logic [DIV_DEN_W-1:0]       div_denom;

   logic [GAIN_W-1:0]          div_quot;
   div_status_type             div_stat;

   fpc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .denom    (div_denom),
      .quotient (div_quot),
      .status   (div_stat)
   );

   // configuration writes
   always_comb begin
      input_gain_in   = input_gain_ff;
      attack_rate_in  = attack_rate_ff;
      release_rate_in = release_rate_ff;
      ratio_amount_in = ratio_amount_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_INPUT_GAIN:   input_gain_in   = csr_wdata;
            CSR_ATTACK_RATE:  attack_rate_in  = csr_wdata;
            CSR_RELEASE_RATE: release_rate_in = csr_wdata;
            CSR_RATIO_AMOUNT: ratio_amount_in = csr_wdata;
         endcase
      end
   end

   // arithmetic around the shared multiplier
   always_comb begin
      y1        = prod_ff[30:15];
      y         = prod_ff[31:7];
      y_neg     = OUT_W'(-y);
      y_mag     = y[OUT_W-1] ? y_neg[OUT_W-2:0] : y[OUT_W-2:0];
      over_pos  = y_mag > (OUT_W-1)'(THRESHOLD);
      over_mag  = y_mag - (OUT_W-1)'(THRESHOLD);
      att_factor = mag16(attack_rate_ff) + CSR_W'(RATE_OFFSET);
      rel_sum    = mag16(release_rate_ff) + CSR_W'(RATE_OFFSET);
      rel_step   = rel_sum[15:9];
      // attack: add the scaled overshoot, cap at the envelope limit
      att_inc   = prod_ff[38:20];
      att_sum   = {3'b000, env_ff} + {1'b0, att_inc};
      env_att   = (att_sum > 20'(ENV_LIMIT)) ? ENV_W'(ENV_LIMIT) : att_sum[ENV_W-1:0];
      // release: fall by the step, floor at zero
      env_rel   = (env_ff > ENV_W'(rel_step)) ? env_ff - ENV_W'(rel_step) : '0;
      // divisor from ratio times envelope, clamped
      div_raw   = prod_ff[32:15];
      div_clamp = (div_raw > 18'(DIV_LIMIT)) ? DIV_DEN_W'(DIV_LIMIT)
                                             : div_raw[DIV_DEN_W-1:0];
      div_denom = div_clamp + DIV_DEN_W'(GAIN_BASE);
   end

   assign mul_p     = mul_a * mul_b;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:       if (req_valid) state_in = ST_MUL_GAIN;
         ST_MUL_GAIN:   state_in = ST_MUL_MAKEUP;
         ST_MUL_MAKEUP: state_in = ST_ATTACK;
         ST_ATTACK:     if (slot_free) state_in = ST_ENV;
         ST_ENV:        state_in = ST_MUL_RATIO;
         ST_MUL_RATIO:  state_in = ST_DIV_START;
         ST_DIV_START:  state_in = ST_DIV_WAIT;
         ST_DIV_WAIT:   if (div_stat.done) state_in = ST_IDLE;
         default:       state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer: operand select and load strobes
   always_comb begin
      req_ready = 1'b0;
      prod_en   = 1'b0;
      rsp_load  = 1'b0;
      env_en    = 1'b0;
      div_start = 1'b0;
      vca_load  = 1'b0;
      mul_a     = '0;
      mul_b     = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
         end
         ST_MUL_GAIN: begin
            prod_en = 1'b1;
            mul_a   = {{(MUL_A_W-SAMPLE_W){x_ff[SAMPLE_W-1]}}, x_ff};
            mul_b   = {2'b00, vca_ff};
         end
         ST_MUL_MAKEUP: begin
            prod_en = 1'b1;
            mul_a   = {{(MUL_A_W-SAMPLE_W){y1[SAMPLE_W-1]}}, y1};
            mul_b   = {{(MUL_B_W-CSR_W){input_gain_ff[CSR_W-1]}}, input_gain_ff};
         end
         ST_ATTACK: begin
            prod_en  = slot_free;
            rsp_load = slot_free;
            mul_a    = {1'b0, over_mag};
            mul_b    = {2'b00, att_factor};
         end
         ST_ENV: begin
            env_en = 1'b1;
         end
         ST_MUL_RATIO: begin
            prod_en = 1'b1;
            mul_a   = {8'd0, env_ff};
            mul_b   = {2'b00, mag16(ratio_amount_ff)};
         end
         ST_DIV_START: begin
            div_start = 1'b1;
         end
         ST_DIV_WAIT: begin
            vca_load = div_stat.done;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // register next values
   always_comb begin
      x_in          = (req_valid && req_ready) ? req_sample_in : x_ff;
      used_in       = (req_valid && req_ready) ? vca_ff : used_ff;
      prod_in       = prod_en ? mul_p : prod_ff;
      over_pos_in   = rsp_load ? over_pos : over_pos_ff;
      rsp_sample_in = rsp_load ? y : rsp_sample_ff;
      rsp_gain_in   = rsp_load ? used_ff : rsp_gain_ff;
      rsp_valid_in  = rsp_load ? 1'b1 : (rsp_valid_ff && !rsp_ready);
      env_in        = env_en ? (over_pos_ff ? env_att : env_rel) : env_ff;
      vca_in        = vca_load ? div_quot : vca_ff;
   end

   // control and persistent state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         rsp_valid_ff    <= 1'b0;
         vca_ff          <= GAIN_W'(UNITY_GAIN);
         env_ff          <= '0;
         over_pos_ff     <= 1'b0;
         input_gain_ff   <= CSR_W'(INPUT_GAIN_RESET);
         attack_rate_ff  <= '0;
         release_rate_ff <= '0;
         ratio_amount_ff <= '0;
      end else begin
         state_ff        <= state_in;
         rsp_valid_ff    <= rsp_valid_in;
         vca_ff          <= vca_in;
         env_ff          <= env_in;
         over_pos_ff     <= over_pos_in;
         input_gain_ff   <= input_gain_in;
         attack_rate_ff  <= attack_rate_in;
         release_rate_ff <= release_rate_in;
         ratio_amount_ff <= ratio_amount_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      x_ff          <= x_in;
      used_ff       <= used_in;
      prod_ff       <= prod_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_gain_ff   <= rsp_gain_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;
   assign rsp_gain_now   = rsp_gain_ff;

   // gain stays within the range the divider can produce
   a_vca_range: assert property (@(posedge clock) disable iff (reset)
      vca_ff >= GAIN_W'(254) && vca_ff <= GAIN_W'(UNITY_GAIN))
      else $error("compressor gain out of range");

   // envelope never exceeds its cap
   a_env_cap: assert property (@(posedge clock) disable iff (reset)
      env_ff <= ENV_W'(ENV_LIMIT))
      else $error("envelope above limit");

   // an accepted sample starts the multiply sequence
   a_accept_seq: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == ST_MUL_GAIN)
      else $error("sequencer did not start after accept");

   // divider is only started when idle
   a_div_start: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_stat.busy)
      else $error("divider restarted while busy");

   // divider completion is only seen while waiting for it
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> state_ff == ST_DIV_WAIT)
      else $error("divider done outside wait state");

endmodule

`default_nettype wire

[test/tb.sv]
`timescale 1ns / 1ps
// Testbench for feedback_peak_compressor: an in-bench gain and envelope predictor
// checks every result beat. Depends on fpc_pkg and the RTL.

module tb;
   import fpc_pkg::*;

   localparam int GAIN_NUMERATOR = 1 << 23;
   localparam int SETTLE_CYCLES  = 40;    // covers one full sample pass
   localparam int STALL_LIMIT    = 2000;  // cycles with no beat on either side
   localparam int HOLD_CYCLES    = 300;

   typedef struct {
      logic signed [OUT_W-1:0] sample;
      logic [GAIN_W-1:0]       gain;
   } comp_result_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic signed [SAMPLE_W-1:0] req_sample_in = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic signed [OUT_W-1:0]    rsp_sample_out;
   logic [GAIN_W-1:0]          rsp_gain_now;
   logic                       csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]       csr_index = '0;
   logic [CSR_W-1:0]           csr_wdata = '0;

   // predictor state and register copies
   logic [GAIN_W-1:0]         pred_gain;
   int                        env_level;
   logic signed [CSR_W-1:0]   cfg_makeup, cfg_attack, cfg_release, cfg_ratio;
   comp_result_type           expected_out[$];

   int idle_pct, stall_pct;
   int hold_seq, hold_seen, hold_left;
   int fail_count, checked, settings_count, env_caps, div_clamps, releases;
   int quiet_cycles;

   feedback_peak_compressor u_top (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic longint magnitude(input longint v);
      return (v < 0) ? -v : v;
   endfunction

   // one sample through the compressor law; updates gain and envelope
   function automatic comp_result_type compress_sample(input logic signed [SAMPLE_W-1:0] x);
      comp_result_type r;
      longint          y, over, div;
      r.gain = pred_gain;
      y = (longint'(x) * longint'(pred_gain)) >>> 15;
      y = (y * longint'(cfg_makeup)) >>> 7;
      r.sample = y[OUT_W-1:0];
      over = magnitude(y) - THRESHOLD;
      if (over > 0) begin
         env_level += int'((over * (magnitude(cfg_attack) + RATE_OFFSET)) >>> 20);
         if (env_level >= ENV_LIMIT) begin
            env_level = ENV_LIMIT;
            env_caps++;
         end
      end else if (env_level > 0) begin
         env_level -= int'((magnitude(cfg_release) + RATE_OFFSET) >> 9);
         if (env_level < 0) env_level = 0;
         releases++;
      end
      div = (magnitude(cfg_ratio) * longint'(env_level)) >>> 15;
      if (div > DIV_LIMIT) begin
         div = DIV_LIMIT;
         div_clamps++;
      end
      pred_gain = GAIN_W'(GAIN_NUMERATOR / (GAIN_BASE + div));
      return r;
   endfunction

   // send one sample beat; predict on acceptance
   task automatic send_sample(input logic signed [SAMPLE_W-1:0] x);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_sample_in <= x;
      do @(posedge clock); while (!req_ready);
      expected_out.push_back(compress_sample(x));
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_out.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // write all four registers once the block is idle
   task automatic set_config(input logic [CSR_W-1:0] makeup, attack, rel, ratio);
      logic [CSR_W-1:0] vals[4];
      vals = '{makeup, attack, rel, ratio};
      wait_idle();
      for (int i = 0; i < 4; i++) begin
         csr_we    <= 1'b1;
         csr_index <= csr_index_type'(i);
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      csr_we      <= 1'b0;
      cfg_makeup  = makeup;
      cfg_attack  = attack;
      cfg_release = rel;
      cfg_ratio   = ratio;
      settings_count++;
   endtask

   function automatic logic [CSR_W-1:0] pick_reg();
      case ($urandom_range(5))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h0000;
         3: return 16'(INPUT_GAIN_RESET);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] pick_sample(input int kind);
      int m;
      case (kind)
         0: return SAMPLE_W'($urandom);
         1: m = $urandom_range(THRESHOLD + 200, THRESHOLD - 200);
         2: m = $urandom_range(500);
         default: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      endcase
      return $urandom_range(1) ? SAMPLE_W'(-m) : SAMPLE_W'(m);
   endfunction

   // defaults: unity gain, threshold edges, full-scale input
   task automatic test_reset_defaults();
      logic signed [SAMPLE_W-1:0] pts[8];
      pts = '{16'sd0, 16'sh7fff, 16'sh8000, 16'sd1, -16'sd1, 16'sd3000, 16'sd3001, -16'sd3001};
      foreach (pts[i]) send_sample(pts[i]);
   endtask

   // envelope cap, divisor clamp, then release toward zero
   task automatic test_saturation();
      set_config(16'h7fff, 16'h8000, 16'h0000, 16'h8000);
      send_sample(16'sh7fff);
      send_sample(16'sh8000);
      send_sample(16'sh7fff);
      send_sample(16'sd0);
      set_config(16'h0080, 16'h0000, 16'h8000, 16'h7fff);
      repeat (5) send_sample(16'sd0);
   endtask

   // most negative makeup gain gives the largest positive output
   task automatic test_extreme_gain();
      set_config(16'h8000, 16'h7fff, 16'h8000, 16'h0000);
      send_sample(16'sh8000);
      send_sample(16'sh7fff);
      send_sample(-16'sd1);
      send_sample(16'sd1);
      send_sample(16'sd0);
   endtask

   // receiver holds off while samples keep coming; input must stall
   task automatic test_backpressure();
      set_config(16'h0100, 16'h1000, 16'h0400, 16'h2000);
      idle_pct  = 0;
      stall_pct = 0;
      hold_seq++;
      repeat (16) send_sample(pick_sample($urandom_range(3)));
   endtask

   // random bursts under each idling mode and several register settings
   task automatic test_random_traffic();
      int idle_modes[4], stall_modes[4], kind;
      idle_modes  = '{0, 80, 0, 9};
      stall_modes = '{0, 0, 80, 9};
      for (int mode = 0; mode < 4; mode++) begin
         for (int s = 0; s < 6; s++) begin
            set_config(pick_reg(), pick_reg(), pick_reg(), pick_reg());
            idle_pct  = idle_modes[mode];
            stall_pct = stall_modes[mode];
            for (int n = 0; n < 48; n++) begin
               if (n % 8 == 0) kind = $urandom_range(3);
               send_sample(pick_sample($urandom_range(3) == 0 ? $urandom_range(3) : kind));
            end
         end
      end
      idle_pct  = 0;
      stall_pct = 0;
   endtask

   // receiver: random ready, long hold-off on request, result check
   always @(posedge clock) begin
      comp_result_type e;
      if (hold_seq != hold_seen) begin
         hold_seen = hold_seq;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_out.size() == 0) begin
            $error("unexpected result beat: sample_out %0d gain_now %0d",
                   rsp_sample_out, rsp_gain_now);
            fail_count++;
         end else begin
            e = expected_out.pop_front();
            checked++;
            if (rsp_sample_out !== e.sample) begin
               $error("sample_out: expected %0d, got %0d", e.sample, rsp_sample_out);
               fail_count++;
            end
            if (rsp_gain_now !== e.gain) begin
               $error("gain_now: expected %0d, got %0d", e.gain, rsp_gain_now);
               fail_count++;
            end
         end
      end
   end

   // watchdog on cycles with no beat accepted
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("watchdog: no beat for %0d cycles, %0d results pending",
                  quiet_cycles, expected_out.size());
         $display("tb: FAIL");
         $finish;
      end
   end

   initial begin
      pred_gain   = GAIN_W'(UNITY_GAIN);
      env_level   = 0;
      cfg_makeup  = CSR_W'(INPUT_GAIN_RESET);
      cfg_attack  = '0;
      cfg_release = '0;
      cfg_ratio   = '0;
      idle_pct = 0;  stall_pct = 0;
      hold_seq = 0;  hold_seen = 0;  hold_left = 0;
      fail_count = 0;  checked = 0;  settings_count = 0;
      env_caps = 0;  div_clamps = 0;  releases = 0;  quiet_cycles = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_saturation();
      test_extreme_gain();
      test_backpressure();
      test_random_traffic();
      wait_idle();

      $display("summary: %0d results checked over %0d register settings plus defaults",
               checked, settings_count);
      $display("summary: envelope capped %0d times, divisor clamped %0d, release steps %0d",
               env_caps, div_clamps, releases);
      if (fail_count == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule
